### rtl/cprf_pkg.sv
package cprf_pkg;

  localparam int DEF_TUNNEL_ENTRIES    = 8;
  localparam int DEF_WHITELIST_ENTRIES = 32;
  localparam int DEF_MAX_PACKET_BYTES  = 512;
  localparam logic [15:0] DEF_UNUSED_ID = 16'd0;

  localparam int IDX_W   = 6;
  localparam int SLOT_W  = 4;

  typedef enum logic [1:0] {
    KIND_PACKET    = 2'd0,
    KIND_TUNNEL    = 2'd1,
    KIND_WHITELIST = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    VERDICT_FORWARDED    = 3'd0,
    VERDICT_NOT_LISTED   = 3'd1,
    VERDICT_TOO_LONG     = 3'd2,
    VERDICT_LEN_MISMATCH = 3'd3,
    VERDICT_BAD_CHECKSUM = 3'd4,
    VERDICT_TABLE_OK     = 3'd5,
    VERDICT_BAD_INDEX    = 3'd6
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REMAP,
    ST_SEARCH,
    ST_DECIDE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic remap;
    logic search;
    logic decide;
  } cprf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_packet;
  } cprf_sts_t;

endpackage

### rtl/command_packet_remap_filter_unit.sv
// A packet beat goes through load, tunnel match, remap, whitelist compare and
// decision, one register stage each, before the next beat is accepted.
// Table writes and counter clears skip the remap and compare steps.
// The result is held in an output register; a decision waits only while that
// register is still stalled.
// Reset clears the tables' valid bits, the counters and the last-remap record.
module command_packet_remap_filter_unit #(
  parameter int          TUNNEL_ENTRIES    = cprf_pkg::DEF_TUNNEL_ENTRIES,
  parameter int          WHITELIST_ENTRIES = cprf_pkg::DEF_WHITELIST_ENTRIES,
  parameter int          MAX_PACKET_BYTES  = cprf_pkg::DEF_MAX_PACKET_BYTES,
  parameter logic [15:0] UNUSED_ID         = cprf_pkg::DEF_UNUSED_ID
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] msg_id_i,
  input  logic [15:0] header_length_i,
  input  logic [15:0] received_length_i,
  input  logic        checksum_ok_i,
  input  logic [5:0]  entry_index_i,
  input  logic        entry_enable_i,
  input  logic [15:0] new_msg_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        forward_o,
  output logic [15:0] out_msg_id_o,
  output logic [2:0]  verdict_o,
  output logic        remapped_o,
  output logic [15:0] received_count_o,
  output logic [15:0] error_count_o,
  output logic [15:0] mapping_count_o,
  output logic [3:0]  last_map_index_o,
  output logic [15:0] last_map_original_o,
  output logic [15:0] last_map_replacement_o
);
  import cprf_pkg::*;

  cprf_cmd_t cmd;
  cprf_sts_t sts;

  cprf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cprf_datapath #(
    .TUNNEL_ENTRIES    (TUNNEL_ENTRIES),
    .WHITELIST_ENTRIES (WHITELIST_ENTRIES),
    .MAX_PACKET_BYTES  (MAX_PACKET_BYTES),
    .UNUSED_ID         (UNUSED_ID)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .kind_i                 (kind_i),
    .msg_id_i               (msg_id_i),
    .header_length_i        (header_length_i),
    .received_length_i      (received_length_i),
    .checksum_ok_i          (checksum_ok_i),
    .entry_index_i          (entry_index_i),
    .entry_enable_i         (entry_enable_i),
    .new_msg_id_i           (new_msg_id_i),
    .forward_o              (forward_o),
    .out_msg_id_o           (out_msg_id_o),
    .verdict_o              (verdict_o),
    .remapped_o             (remapped_o),
    .received_count_o       (received_count_o),
    .error_count_o          (error_count_o),
    .mapping_count_o        (mapping_count_o),
    .last_map_index_o       (last_map_index_o),
    .last_map_original_o    (last_map_original_o),
    .last_map_replacement_o (last_map_replacement_o)
  );

endmodule

### rtl/cprf_ctrl.sv
module cprf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  cprf_pkg::cprf_sts_t sts_i,
  output cprf_pkg::cprf_cmd_t cmd_o
);
  import cprf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    // A waiting result is dropped once the downstream side takes the beat.
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = sts_i.is_packet ? ST_REMAP : ST_DECIDE;
      end
      ST_REMAP: begin
        cmd_o.remap = 1'b1;
        state_d     = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.decide = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/cprf_datapath.sv
module cprf_datapath #(
  parameter int          TUNNEL_ENTRIES    = cprf_pkg::DEF_TUNNEL_ENTRIES,
  parameter int          WHITELIST_ENTRIES = cprf_pkg::DEF_WHITELIST_ENTRIES,
  parameter int          MAX_PACKET_BYTES  = cprf_pkg::DEF_MAX_PACKET_BYTES,
  parameter logic [15:0] UNUSED_ID         = cprf_pkg::DEF_UNUSED_ID
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cprf_pkg::cprf_cmd_t cmd_i,
  output cprf_pkg::cprf_sts_t sts_o,
  input  logic [1:0]          kind_i,
  input  logic [15:0]         msg_id_i,
  input  logic [15:0]         header_length_i,
  input  logic [15:0]         received_length_i,
  input  logic                checksum_ok_i,
  input  logic [5:0]          entry_index_i,
  input  logic                entry_enable_i,
  input  logic [15:0]         new_msg_id_i,
  output logic                forward_o,
  output logic [15:0]         out_msg_id_o,
  output logic [2:0]          verdict_o,
  output logic                remapped_o,
  output logic [15:0]         received_count_o,
  output logic [15:0]         error_count_o,
  output logic [15:0]         mapping_count_o,
  output logic [3:0]          last_map_index_o,
  output logic [15:0]         last_map_original_o,
  output logic [15:0]         last_map_replacement_o
);
  import cprf_pkg::*;

  localparam int TIDX_W = (TUNNEL_ENTRIES > 1) ? $clog2(TUNNEL_ENTRIES) : 1;
  localparam int WIDX_W = (WHITELIST_ENTRIES > 1) ? $clog2(WHITELIST_ENTRIES) : 1;

  // Beat held for the whole of its processing.
  logic [1:0]       kind_q;
  logic [15:0]      id_q, hlen_q, rlen_q, newid_q;
  logic             csum_q, ena_q;
  logic [IDX_W-1:0] idx_q;

  // Tables.
  logic [TUNNEL_ENTRIES-1:0]    tun_valid_q;
  logic [15:0]                  tun_orig_q [TUNNEL_ENTRIES];
  logic [15:0]                  tun_repl_q [TUNNEL_ENTRIES];
  logic [WHITELIST_ENTRIES-1:0] wl_valid_q;
  logic [15:0]                  wl_id_q [WHITELIST_ENTRIES];

  // Working registers.
  logic                         tun_hit_q, tun_hit_d;
  logic [TIDX_W-1:0]            tun_slot_q, tun_slot_d;
  logic [TUNNEL_ENTRIES-1:0]    tun_vec;
  logic [15:0]                  mapped_id_q;
  logic [WHITELIST_ENTRIES-1:0] wl_vec_q, wl_vec_d;

  // Status and result registers.
  logic [15:0]       seen_q, seen_d, rej_q, rej_d, maps_q, maps_d;
  logic [SLOT_W-1:0] last_slot_q, last_slot_d;
  logic [15:0]       last_from_q, last_from_d, last_to_q, last_to_d;
  logic              fwd_q, fwd_d, remap_out_q, remap_out_d;
  logic [15:0]       outid_q, outid_d;
  verdict_e          verdict_q, verdict_d;

  logic too_long, len_mismatch, tun_idx_ok, wl_idx_ok, tun_wr, wl_wr;

  assign too_long     = rlen_q > 16'(MAX_PACKET_BYTES);
  assign len_mismatch = hlen_q != rlen_q;
  assign tun_idx_ok   = idx_q < IDX_W'(TUNNEL_ENTRIES);
  assign wl_idx_ok    = 7'(idx_q) < 7'(WHITELIST_ENTRIES);
  assign tun_wr = cmd_i.decide && (kind_e'(kind_q) == KIND_TUNNEL) && tun_idx_ok;
  assign wl_wr  = cmd_i.decide && (kind_e'(kind_q) == KIND_WHITELIST) && wl_idx_ok;

  assign sts_o.is_packet = kind_e'(kind_q) == KIND_PACKET;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      id_q    <= msg_id_i;
      hlen_q  <= header_length_i;
      rlen_q  <= received_length_i;
      csum_q  <= checksum_ok_i;
      idx_q   <= entry_index_i;
      ena_q   <= entry_enable_i;
      newid_q <= new_msg_id_i;
    end
  end

  // Tunnel match: one comparator per entry, lowest enabled match wins.
  always_comb begin
    tun_hit_d  = 1'b0;
    tun_slot_d = '0;
    for (int k = 0; k < TUNNEL_ENTRIES; k++) begin
      tun_vec[k] = tun_valid_q[k] && (tun_orig_q[k] == id_q);
    end
    for (int k = TUNNEL_ENTRIES - 1; k >= 0; k--) begin
      if (tun_vec[k]) begin
        tun_hit_d  = 1'b1;
        tun_slot_d = TIDX_W'(k);
      end
    end
    // Overlong packets are never remapped.
    tun_hit_d = tun_hit_d && !too_long;
  end

  always_comb begin
    for (int k = 0; k < WHITELIST_ENTRIES; k++) begin
      wl_vec_d[k] = wl_valid_q[k] && (wl_id_q[k] == mapped_id_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      tun_hit_q  <= tun_hit_d;
      tun_slot_q <= tun_slot_d;
    end
    if (cmd_i.remap) begin
      mapped_id_q <= tun_hit_q ? tun_repl_q[tun_slot_q] : id_q;
    end
    if (cmd_i.search) begin
      wl_vec_q <= wl_vec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tun_valid_q <= '0;
      for (int k = 0; k < TUNNEL_ENTRIES; k++) begin
        tun_orig_q[k] <= UNUSED_ID;
        tun_repl_q[k] <= UNUSED_ID;
      end
    end else if (tun_wr) begin
      tun_valid_q[idx_q[TIDX_W-1:0]] <= ena_q;
      tun_orig_q[idx_q[TIDX_W-1:0]]  <= ena_q ? id_q : UNUSED_ID;
      tun_repl_q[idx_q[TIDX_W-1:0]]  <= ena_q ? newid_q : UNUSED_ID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_valid_q <= '0;
    end else if (wl_wr) begin
      wl_valid_q[idx_q[WIDX_W-1:0]] <= ena_q;
    end
  end

  // Whitelist ids are only compared behind their valid bits.
  always_ff @(posedge clk_i) begin
    if (wl_wr) begin
      wl_id_q[idx_q[WIDX_W-1:0]] <= ena_q ? id_q : 16'd0;
    end
  end

  always_comb begin
    seen_d      = seen_q;
    rej_d       = rej_q;
    maps_d      = maps_q;
    last_slot_d = last_slot_q;
    last_from_d = last_from_q;
    last_to_d   = last_to_q;
    fwd_d       = 1'b0;
    remap_out_d = 1'b0;
    outid_d     = 16'd0;
    verdict_d   = VERDICT_TABLE_OK;
    unique case (kind_e'(kind_q))
      KIND_PACKET: begin
        seen_d      = seen_q + 16'd1;
        outid_d     = mapped_id_q;
        remap_out_d = tun_hit_q;
        if (tun_hit_q) begin
          maps_d      = maps_q + 16'd1;
          last_slot_d = SLOT_W'(tun_slot_q);
          last_from_d = id_q;
          last_to_d   = mapped_id_q;
        end
        if (too_long) begin
          rej_d     = rej_q + 16'd1;
          verdict_d = VERDICT_TOO_LONG;
        end else if (len_mismatch) begin
          rej_d     = rej_q + 16'd1;
          verdict_d = VERDICT_LEN_MISMATCH;
        end else if (!csum_q && !tun_hit_q) begin
          rej_d     = rej_q + 16'd1;
          verdict_d = VERDICT_BAD_CHECKSUM;
        end else if (|wl_vec_q) begin
          fwd_d     = 1'b1;
          verdict_d = VERDICT_FORWARDED;
        end else begin
          verdict_d = VERDICT_NOT_LISTED;
        end
      end
      KIND_TUNNEL: begin
        if (!tun_idx_ok) verdict_d = VERDICT_BAD_INDEX;
      end
      KIND_WHITELIST: begin
        if (!wl_idx_ok) verdict_d = VERDICT_BAD_INDEX;
      end
      KIND_CLEAR: begin
        seen_d      = 16'd0;
        rej_d       = 16'd0;
        maps_d      = 16'd0;
        last_slot_d = SLOT_W'(TUNNEL_ENTRIES);
        last_from_d = UNUSED_ID;
        last_to_d   = UNUSED_ID;
      end
      default: begin
        verdict_d = VERDICT_TABLE_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 16'd0;
      rej_q       <= 16'd0;
      maps_q      <= 16'd0;
      last_slot_q <= SLOT_W'(TUNNEL_ENTRIES);
      last_from_q <= UNUSED_ID;
      last_to_q   <= UNUSED_ID;
    end else if (cmd_i.decide) begin
      seen_q      <= seen_d;
      rej_q       <= rej_d;
      maps_q      <= maps_d;
      last_slot_q <= last_slot_d;
      last_from_q <= last_from_d;
      last_to_q   <= last_to_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      fwd_q       <= fwd_d;
      remap_out_q <= remap_out_d;
      outid_q     <= outid_d;
      verdict_q   <= verdict_d;
    end
  end

  // The counters only move on a decision, which waits for the previous beat
  // to leave, so they can be shown directly.
  assign forward_o              = fwd_q;
  assign out_msg_id_o           = outid_q;
  assign verdict_o              = verdict_q;
  assign remapped_o             = remap_out_q;
  assign received_count_o       = seen_q;
  assign error_count_o          = rej_q;
  assign mapping_count_o        = maps_q;
  assign last_map_index_o       = last_slot_q;
  assign last_map_original_o    = last_from_q;
  assign last_map_replacement_o = last_to_q;

endmodule

### test/tb_command_packet_remap_filter_unit.sv
module tb_command_packet_remap_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cprf_pkg::*;

  localparam int          TUN_N       = DEF_TUNNEL_ENTRIES;
  localparam int          WL_N        = DEF_WHITELIST_ENTRIES;
  localparam int          TUN_IW      = $clog2(TUN_N);
  localparam int          WL_IW       = $clog2(WL_N);
  localparam int          MAX_BYTES   = DEF_MAX_PACKET_BYTES;
  localparam logic [15:0] NO_ID       = DEF_UNUSED_ID;
  localparam int          HOLD_CYCLES = 200;
  localparam int          PHASE_BEATS = 250;

  typedef struct {
    kind_e       kind;
    logic [15:0] msg_id;
    logic [15:0] header_length;
    logic [15:0] received_length;
    logic        checksum_ok;
    logic [5:0]  entry_index;
    logic        entry_enable;
    logic [15:0] new_msg_id;
  } cmd_beat_t;

  typedef struct {
    logic        forward;
    logic [15:0] out_msg_id;
    verdict_e    verdict;
    logic        remapped;
    logic [15:0] received_count;
    logic [15:0] error_count;
    logic [15:0] mapping_count;
    logic [3:0]  last_map_index;
    logic [15:0] last_map_original;
    logic [15:0] last_map_replacement;
  } filter_result_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i            = KIND_PACKET;
  logic [15:0] msg_id_i          = '0;
  logic [15:0] header_length_i   = '0;
  logic [15:0] received_length_i = '0;
  logic        checksum_ok_i     = 1'b0;
  logic [5:0]  entry_index_i     = '0;
  logic        entry_enable_i    = 1'b0;
  logic [15:0] new_msg_id_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic        forward_o;
  logic [15:0] out_msg_id_o;
  logic [2:0]  verdict_o;
  logic        remapped_o;
  logic [15:0] received_count_o;
  logic [15:0] error_count_o;
  logic [15:0] mapping_count_o;
  logic [3:0]  last_map_index_o;
  logic [15:0] last_map_original_o;
  logic [15:0] last_map_replacement_o;

  // Shadow copy of the filter state.
  logic        tun_on   [TUN_N] = '{default: 1'b0};
  logic [15:0] tun_from [TUN_N] = '{default: NO_ID};
  logic [15:0] tun_to   [TUN_N] = '{default: NO_ID};
  logic        wl_on    [WL_N]  = '{default: 1'b0};
  logic [15:0] wl_id    [WL_N]  = '{default: 16'h0000};
  logic [15:0] rx_count  = '0;
  logic [15:0] err_count = '0;
  logic [15:0] map_count = '0;
  logic [3:0]  map_slot  = 4'(TUN_N);
  logic [15:0] map_from  = NO_ID;
  logic [15:0] map_to    = NO_ID;

  filter_result_t pending_results[$];
  logic [15:0]    id_pool [8];
  int             mismatches   = 0;
  int             idle_pct     = 0;
  int             stall_pct    = 0;
  logic           hold_request = 1'b0;
  int             hold_left    = 0;

  command_packet_remap_filter_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .kind_i                (kind_i),
    .msg_id_i              (msg_id_i),
    .header_length_i       (header_length_i),
    .received_length_i     (received_length_i),
    .checksum_ok_i         (checksum_ok_i),
    .entry_index_i         (entry_index_i),
    .entry_enable_i        (entry_enable_i),
    .new_msg_id_i          (new_msg_id_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .forward_o             (forward_o),
    .out_msg_id_o          (out_msg_id_o),
    .verdict_o             (verdict_o),
    .remapped_o            (remapped_o),
    .received_count_o      (received_count_o),
    .error_count_o         (error_count_o),
    .mapping_count_o       (mapping_count_o),
    .last_map_index_o      (last_map_index_o),
    .last_map_original_o   (last_map_original_o),
    .last_map_replacement_o(last_map_replacement_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic filter_result_t filter_predict(input cmd_beat_t b);
    filter_result_t r;
    logic           hit;
    hit          = 1'b0;
    r.forward    = 1'b0;
    r.out_msg_id = 16'h0000;
    r.verdict    = VERDICT_TABLE_OK;
    r.remapped   = 1'b0;
    case (b.kind)
      KIND_PACKET: begin
        rx_count     = rx_count + 16'd1;
        r.out_msg_id = b.msg_id;
        if (b.received_length > 16'(MAX_BYTES)) begin
          err_count = err_count + 16'd1;
          r.verdict = VERDICT_TOO_LONG;
        end else begin
          // The lowest-numbered enabled tunnel entry wins.
          for (int k = 0; k < TUN_N; k++) begin
            if (!hit && tun_on[k] && tun_from[k] == b.msg_id) begin
              hit          = 1'b1;
              r.out_msg_id = tun_to[k];
              map_count    = map_count + 16'd1;
              map_slot     = 4'(k);
              map_from     = b.msg_id;
              map_to       = tun_to[k];
            end
          end
          r.remapped = hit;
          if (b.header_length != b.received_length) begin
            err_count = err_count + 16'd1;
            r.verdict = VERDICT_LEN_MISMATCH;
          end else if (!b.checksum_ok && !hit) begin
            err_count = err_count + 16'd1;
            r.verdict = VERDICT_BAD_CHECKSUM;
          end else begin
            r.verdict = VERDICT_NOT_LISTED;
            for (int k = 0; k < WL_N; k++) begin
              if (wl_on[k] && wl_id[k] == r.out_msg_id) begin
                r.verdict = VERDICT_FORWARDED;
                r.forward = 1'b1;
              end
            end
          end
        end
      end
      KIND_TUNNEL: begin
        if (b.entry_index < 6'(TUN_N)) begin
          tun_on[b.entry_index[TUN_IW-1:0]]   = b.entry_enable;
          tun_from[b.entry_index[TUN_IW-1:0]] = b.entry_enable ? b.msg_id : NO_ID;
          tun_to[b.entry_index[TUN_IW-1:0]]   = b.entry_enable ? b.new_msg_id : NO_ID;
        end else begin
          r.verdict = VERDICT_BAD_INDEX;
        end
      end
      KIND_WHITELIST: begin
        if (b.entry_index < 6'(WL_N)) begin
          wl_on[b.entry_index[WL_IW-1:0]] = b.entry_enable;
          wl_id[b.entry_index[WL_IW-1:0]] = b.entry_enable ? b.msg_id : 16'h0000;
        end else begin
          r.verdict = VERDICT_BAD_INDEX;
        end
      end
      default: begin
        rx_count  = '0;
        err_count = '0;
        map_count = '0;
        map_slot  = 4'(TUN_N);
        map_from  = NO_ID;
        map_to    = NO_ID;
      end
    endcase
    r.received_count       = rx_count;
    r.error_count          = err_count;
    r.mapping_count        = map_count;
    r.last_map_index       = map_slot;
    r.last_map_original    = map_from;
    r.last_map_replacement = map_to;
    return r;
  endfunction

  function automatic cmd_beat_t make_beat(input kind_e k, input logic [15:0] id,
                                          input logic [15:0] hlen, input logic [15:0] rlen,
                                          input logic csum, input logic [5:0] idx,
                                          input logic ena, input logic [15:0] newid);
    cmd_beat_t b;
    b.kind            = k;
    b.msg_id          = id;
    b.header_length   = hlen;
    b.received_length = rlen;
    b.checksum_ok     = csum;
    b.entry_index     = idx;
    b.entry_enable    = ena;
    b.new_msg_id      = newid;
    return b;
  endfunction

  function automatic logic [15:0] pick_id();
    if ($urandom_range(99) < 85) begin
      return id_pool[3'($urandom_range(7))];
    end
    return 16'($urandom);
  endfunction

  // Mostly well-formed packets over a small id pool, so that the tables get hit.
  function automatic cmd_beat_t random_beat();
    cmd_beat_t   b;
    int unsigned sel;
    int unsigned len_sel;
    sel     = $urandom_range(99);
    len_sel = $urandom_range(99);
    if (sel < 70) begin
      b.kind = KIND_PACKET;
    end else if (sel < 82) begin
      b.kind = KIND_TUNNEL;
    end else if (sel < 96) begin
      b.kind = KIND_WHITELIST;
    end else begin
      b.kind = KIND_CLEAR;
    end
    b.msg_id       = pick_id();
    b.new_msg_id   = pick_id();
    b.checksum_ok  = ($urandom_range(99) < 80);
    b.entry_enable = ($urandom_range(99) < 75);
    if ($urandom_range(99) < 15) begin
      b.entry_index = 6'($urandom_range(63));
    end else if (b.kind == KIND_TUNNEL) begin
      b.entry_index = 6'($urandom_range(TUN_N - 1));
    end else begin
      b.entry_index = 6'($urandom_range(WL_N - 1));
    end
    if (len_sel < 80) begin
      b.received_length = 16'($urandom_range(MAX_BYTES));
      b.header_length   = b.received_length;
    end else if (len_sel < 88) begin
      b.received_length = 16'($urandom_range(MAX_BYTES));
      b.header_length   = 16'($urandom);
    end else if (len_sel < 95) begin
      b.received_length = 16'($urandom_range(65535, MAX_BYTES + 1));
      b.header_length   = b.received_length;
    end else begin
      b.received_length = 16'($urandom);
      b.header_length   = 16'($urandom);
    end
    return b;
  endfunction

  task automatic send_beat(input cmd_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= b.kind;
    msg_id_i          <= b.msg_id;
    header_length_i   <= b.header_length;
    received_length_i <= b.received_length;
    checksum_ok_i     <= b.checksum_ok;
    entry_index_i     <= b.entry_index;
    entry_enable_i    <= b.entry_enable;
    new_msg_id_i      <= b.new_msg_id;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(filter_predict(b));
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting (verdict %0d)", verdict_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("forward", 16'(want.forward), 16'(forward_o));
        check_field("out_msg_id", want.out_msg_id, out_msg_id_o);
        check_field("verdict", 16'(want.verdict), 16'(verdict_o));
        check_field("remapped", 16'(want.remapped), 16'(remapped_o));
        check_field("received_count", want.received_count, received_count_o);
        check_field("error_count", want.error_count, error_count_o);
        check_field("mapping_count", want.mapping_count, mapping_count_o);
        check_field("last_map_index", 16'(want.last_map_index),
                    16'(last_map_index_o));
        check_field("last_map_original", want.last_map_original, last_map_original_o);
        check_field("last_map_replacement", want.last_map_replacement,
                    last_map_replacement_o);
      end
    end
  end

  task automatic test_tables();
    send_beat(make_beat(KIND_WHITELIST, 16'h1234, 16'd0, 16'd0, 1'b0, 6'd0, 1'b1, 16'h0000));
    send_beat(make_beat(KIND_WHITELIST, 16'hFFFF, 16'd0, 16'd0, 1'b0, 6'd31, 1'b1, 16'h0000));
    // A second whitelist entry holding the same id.
    send_beat(make_beat(KIND_WHITELIST, 16'h1234, 16'd0, 16'd0, 1'b0, 6'd5, 1'b1, 16'h0000));
    send_beat(make_beat(KIND_WHITELIST, 16'h4321, 16'd0, 16'd0, 1'b0, 6'd32, 1'b1, 16'h0000));
    send_beat(make_beat(KIND_WHITELIST, 16'h4321, 16'd0, 16'd0, 1'b0, 6'd63, 1'b1, 16'h0000));
    send_beat(make_beat(KIND_TUNNEL, 16'h0100, 16'd0, 16'd0, 1'b0, 6'd0, 1'b1, 16'h1234));
    send_beat(make_beat(KIND_TUNNEL, 16'h0100, 16'd0, 16'd0, 1'b0, 6'd3, 1'b1, 16'h5555));
    send_beat(make_beat(KIND_TUNNEL, 16'hFFFF, 16'd0, 16'd0, 1'b0, 6'd7, 1'b1, 16'hABCD));
    send_beat(make_beat(KIND_TUNNEL, 16'h0200, 16'd0, 16'd0, 1'b1, 6'd8, 1'b1, 16'h1234));
    send_beat(make_beat(KIND_TUNNEL, 16'h0200, 16'd0, 16'd0, 1'b1, 6'd63, 1'b1, 16'hFFFF));
  endtask

  task automatic test_packet_paths();
    send_beat(make_beat(KIND_PACKET, 16'h1234, 16'd20, 16'd20, 1'b1, 6'd0, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_PACKET, 16'h2222, 16'd20, 16'd20, 1'b1, 6'd0, 1'b0, 16'h0000));
    // A remapped packet passes even with a failed checksum.
    send_beat(make_beat(KIND_PACKET, 16'h0100, 16'(MAX_BYTES), 16'(MAX_BYTES), 1'b0,
                        6'd0, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_PACKET, 16'h0100, 16'(MAX_BYTES + 1), 16'(MAX_BYTES + 1),
                        1'b1, 6'd0, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_PACKET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 6'h3F, 1'b1,
                        16'hFFFF));
    send_beat(make_beat(KIND_PACKET, 16'h0100, 16'd10, 16'd11, 1'b1, 6'd0, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_PACKET, 16'h1234, 16'd8, 16'd8, 1'b0, 6'd0, 1'b0, 16'h0000));
    // Disabled tunnel entries hold the unused id and must not match it.
    send_beat(make_beat(KIND_PACKET, NO_ID, 16'd0, 16'd0, 1'b1, 6'd0, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_TUNNEL, 16'h0100, 16'd0, 16'd0, 1'b0, 6'd0, 1'b0, 16'h1234));
    send_beat(make_beat(KIND_PACKET, 16'h0100, 16'd30, 16'd30, 1'b1, 6'd0, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_WHITELIST, 16'h1234, 16'd0, 16'd0, 1'b0, 6'd0, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_WHITELIST, 16'h1234, 16'd0, 16'd0, 1'b0, 6'd5, 1'b0, 16'h0000));
    send_beat(make_beat(KIND_PACKET, 16'h1234, 16'd40, 16'd40, 1'b1, 6'd0, 1'b0, 16'h0000));
  endtask

  task automatic test_counter_clear();
    send_beat(make_beat(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 6'h3F, 1'b1,
                        16'hFFFF));
    send_beat(make_beat(KIND_PACKET, 16'hFFFF, 16'd64, 16'd64, 1'b1, 6'd0, 1'b0, 16'h0000));
  endtask

  task automatic test_random_phase(input int sender_idle, input int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    id_pool[0] = NO_ID;
    repeat (PHASE_BEATS) send_beat(random_beat());
  endtask

  // The receiver holds off while beats keep coming, so the block backs up.
  task automatic test_backpressure();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    repeat (40) send_beat(random_beat());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tables();
    test_packet_paths();
    test_counter_clear();
    test_random_phase(0, 0);
    test_random_phase(48, 0);
    test_random_phase(0, 48);
    test_random_phase(8, 8);
    test_backpressure();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_command_packet_remap_filter_unit passed");
    end else begin
      $display("tb_command_packet_remap_filter_unit failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_command_packet_remap_filter_unit failed");
    $finish;
  end

endmodule
